/* hw/rtl/rpm_pkg.sv */
// Shared types and constants for the RMS and peak level meter.
// No dependencies. Used by rpm_ctrl, rpm_datapath and rms_peak_level_meter.
`default_nettype none

package rpm_pkg;

	localparam int SAMPLE_BITS = 16;
	// sample port is 16 bits, wider only when the sample itself is wider
	localparam int IN_BITS     = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
	localparam int COUNT_BITS  = 16;
	localparam int PEAK_BITS   = SAMPLE_BITS - 1;
	localparam int SQUARE_BITS = 2 * SAMPLE_BITS;
	// worst case: (2^(SAMPLE_BITS-1))^2 * 65535 stays below 2^(2*SAMPLE_BITS+14)
	localparam int SUM_BITS    = 2 * SAMPLE_BITS + 14;
	localparam int ROOT_BITS   = SUM_BITS / 2;
	localparam int DREM_BITS   = COUNT_BITS + 1;
	localparam int SREM_BITS   = ROOT_BITS + 2;
	localparam int STEP_BITS   = $clog2(SUM_BITS);

	localparam int SHL = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
	localparam int SHR = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
	localparam int RMS_SCALE_BITS  = ROOT_BITS + 16;
	localparam int PEAK_SCALE_BITS = PEAK_BITS + 16;

	localparam int RMS_BITS     = 16;
	localparam int PEAK_OUT_BITS = 15;
	localparam int RMS_MAX      = 32768;
	localparam int PEAK_MAX     = 32767;

	localparam int ADDR_BITS = 2;
	localparam int DATA_BITS = 32;
	localparam logic [ADDR_BITS-1:0] ADDR_WINDOW = 2'd0;
	localparam logic [COUNT_BITS-1:0] WINDOW_RESET = 16'd4410;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_ROOT,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic take;      // sample transfer this cycle
		logic div_en;    // one restoring-divide step
		logic root_en;   // one square-root step
		logic publish;   // load the result register
	} cmd_t;

	typedef struct packed {
		logic close;     // the offered sample closes its window
		logic div_last;
		logic root_last;
		logic out_free;  // result register empty or draining this cycle
	} stat_t;

	function automatic logic [RMS_BITS-1:0] rms_scale(input logic [ROOT_BITS-1:0] r);
		logic [RMS_SCALE_BITS-1:0] w;
		w = RMS_SCALE_BITS'(r);
		w = (w << SHL) >> SHR;
		if (w > RMS_SCALE_BITS'(RMS_MAX))
			return RMS_BITS'(RMS_MAX);
		return w[RMS_BITS-1:0];
	endfunction

	function automatic logic [PEAK_OUT_BITS-1:0] peak_scale(input logic [PEAK_BITS-1:0] p);
		logic [PEAK_SCALE_BITS-1:0] w;
		w = PEAK_SCALE_BITS'(p);
		w = (w << SHL) >> SHR;
		if (w > PEAK_SCALE_BITS'(PEAK_MAX))
			return PEAK_OUT_BITS'(PEAK_MAX);
		return w[PEAK_OUT_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/rpm_ctrl.sv */
// Sequencer for the level meter: accumulate, divide, root, deliver.
// Depends on rpm_pkg; drives the command struct of rpm_datapath.
`default_nettype none

module rpm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  rpm_pkg::stat_t     stat,
	output rpm_pkg::cmd_t      cmd
);

	rpm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rpm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			rpm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (stat.close)
						state_d = rpm_pkg::ST_DIVIDE;
				end
			end
			rpm_pkg::ST_DIVIDE: begin
				cmd.div_en = 1'b1;
				if (stat.div_last)
					state_d = rpm_pkg::ST_ROOT;
			end
			rpm_pkg::ST_ROOT: begin
				cmd.root_en = 1'b1;
				if (stat.root_last)
					state_d = rpm_pkg::ST_DELIVER;
			end
			rpm_pkg::ST_DELIVER: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = rpm_pkg::ST_IDLE;
				end
			end
			default: state_d = rpm_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/rpm_datapath.sv */
// Datapath: square-sum accumulator, running peak, restoring divider,
// digit-by-digit square root and result register. Depends on rpm_pkg.
`default_nettype none

module rpm_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  rpm_pkg::cmd_t                          cmd,
	output rpm_pkg::stat_t                         stat,
	input  wire logic [rpm_pkg::IN_BITS-1:0]       sample,
	input  wire logic [rpm_pkg::COUNT_BITS-1:0]    window,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [rpm_pkg::RMS_BITS-1:0]           rms_level,
	output logic [rpm_pkg::PEAK_OUT_BITS-1:0]      peak_level,
	output logic [rpm_pkg::COUNT_BITS-1:0]         sample_count
);

	localparam int SB = rpm_pkg::SAMPLE_BITS;

	logic [rpm_pkg::SUM_BITS-1:0]    sum_q;
	logic [rpm_pkg::PEAK_BITS-1:0]   peak_q;
	logic [rpm_pkg::COUNT_BITS-1:0]  seen_q;

	logic [rpm_pkg::SUM_BITS-1:0]    quo_q;   // dividend, then quotient, then root source
	logic [rpm_pkg::COUNT_BITS-1:0]  divisor_q;
	logic [rpm_pkg::DREM_BITS-1:0]   drem_q;
	logic [rpm_pkg::ROOT_BITS-1:0]   root_q;
	logic [rpm_pkg::SREM_BITS-1:0]   srem_q;
	logic [rpm_pkg::STEP_BITS-1:0]   step_q;
	logic [rpm_pkg::PEAK_BITS-1:0]   peak_hold_q;
	logic [rpm_pkg::COUNT_BITS-1:0]  count_hold_q;

	logic                            valid_q;
	logic [rpm_pkg::RMS_BITS-1:0]    rms_q;
	logic [rpm_pkg::PEAK_OUT_BITS-1:0] peak_out_q;
	logic [rpm_pkg::COUNT_BITS-1:0]  count_out_q;

	logic [SB-1:0]                   raw;
	logic                            neg;
	logic [SB-1:0]                   mag;
	logic [rpm_pkg::SQUARE_BITS-1:0] square;
	logic [rpm_pkg::SUM_BITS-1:0]    sum_next;
	logic [rpm_pkg::PEAK_BITS-1:0]   peak_next;
	logic [rpm_pkg::COUNT_BITS-1:0]  seen_next;
	logic [rpm_pkg::COUNT_BITS-1:0]  win_eff;

	logic [rpm_pkg::DREM_BITS-1:0]   dshift;
	logic                            dfit;
	logic [rpm_pkg::SREM_BITS-1:0]   sshift;
	logic [rpm_pkg::SREM_BITS-1:0]   trial;
	logic                            sfit;

	// ---- per-sample accumulate ----
	always_comb begin
		raw       = sample[SB-1:0];
		neg       = raw[SB-1];
		// two's complement negate; the most negative code comes out as full scale
		mag       = neg ? (~raw + SB'(1)) : raw;
		square    = rpm_pkg::SQUARE_BITS'(mag) * rpm_pkg::SQUARE_BITS'(mag);
		sum_next  = sum_q + rpm_pkg::SUM_BITS'(square);
		peak_next = (!neg && (raw[SB-2:0] > peak_q)) ? raw[SB-2:0] : peak_q;
		seen_next = seen_q + rpm_pkg::COUNT_BITS'(1);
		win_eff   = (window == '0) ? rpm_pkg::COUNT_BITS'(1) : window;
	end

	always_comb begin
		dshift = {drem_q[rpm_pkg::DREM_BITS-2:0], quo_q[rpm_pkg::SUM_BITS-1]};
		dfit   = dshift >= rpm_pkg::DREM_BITS'(divisor_q);
		sshift = {srem_q[rpm_pkg::SREM_BITS-3:0], quo_q[rpm_pkg::SUM_BITS-1 -: 2]};
		trial  = {root_q, 2'b01};
		sfit   = sshift >= trial;
	end

	always_comb begin
		stat.close     = (seen_next >= win_eff) && (seen_next != '0);
		stat.div_last  = step_q == rpm_pkg::STEP_BITS'(rpm_pkg::SUM_BITS - 1);
		stat.root_last = step_q == rpm_pkg::STEP_BITS'(rpm_pkg::ROOT_BITS - 1);
		stat.out_free  = !valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			peak_q <= '0;
			seen_q <= '0;
		end else if (cmd.take) begin
			if (stat.close) begin
				sum_q  <= '0;
				peak_q <= '0;
				seen_q <= '0;
			end else begin
				sum_q  <= sum_next;
				peak_q <= peak_next;
				seen_q <= seen_next;
			end
		end
	end

	// ---- divide by count, then root of the quotient ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (cmd.take)
			step_q <= '0;
		else if (cmd.div_en)
			step_q <= stat.div_last ? '0 : step_q + rpm_pkg::STEP_BITS'(1);
		else if (cmd.root_en)
			step_q <= stat.root_last ? '0 : step_q + rpm_pkg::STEP_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.take && stat.close) begin
			quo_q        <= sum_next;
			divisor_q    <= seen_next;
			drem_q       <= '0;
			root_q       <= '0;
			srem_q       <= '0;
			peak_hold_q  <= peak_next;
			count_hold_q <= seen_next;
		end else if (cmd.div_en) begin
			drem_q <= dfit ? dshift - rpm_pkg::DREM_BITS'(divisor_q) : dshift;
			quo_q  <= {quo_q[rpm_pkg::SUM_BITS-2:0], dfit};
		end else if (cmd.root_en) begin
			srem_q <= sfit ? sshift - trial : sshift;
			root_q <= {root_q[rpm_pkg::ROOT_BITS-2:0], sfit};
			quo_q  <= {quo_q[rpm_pkg::SUM_BITS-3:0], 2'b00};
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.publish)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			rms_q       <= rpm_pkg::rms_scale(root_q);
			peak_out_q  <= rpm_pkg::peak_scale(peak_hold_q);
			count_out_q <= count_hold_q;
		end
	end

	assign out_valid    = valid_q;
	assign rms_level    = rms_q;
	assign peak_level   = peak_out_q;
	assign sample_count = count_out_q;

endmodule

`default_nettype wire

/* hw/rtl/rms_peak_level_meter.sv */
// Top level of the RMS and peak level meter: config register and APB port,
// controller and datapath. Depends on rpm_pkg, rpm_ctrl, rpm_datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    sample
//   result    out        out_valid / out_stall  rms_level, peak_level, sample_count
//   config    APB        psel/penable/pready    paddr, pwdata, prdata (window_samples)
//
// A sample that does not close its window leaves the input open, so the next one
// can be taken in the following cycle.
// A closing sample starts a 46-step restoring divide and a 23-step root in one
// shared step counter, then the load of the result register, with in_stall high
// throughout. A stalled result holds the block only at that load.
// Reset clears the sums, counters and result valid; window_samples resets to 4410.
`default_nettype none

module rms_peak_level_meter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [rpm_pkg::IN_BITS-1:0]      sample,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [rpm_pkg::RMS_BITS-1:0]          rms_level,
	output logic [rpm_pkg::PEAK_OUT_BITS-1:0]     peak_level,
	output logic [rpm_pkg::COUNT_BITS-1:0]        sample_count,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [rpm_pkg::ADDR_BITS-1:0]    paddr,
	input  wire logic [rpm_pkg::DATA_BITS-1:0]    pwdata,
	output logic [rpm_pkg::DATA_BITS-1:0]         prdata,
	output logic                                  pready
);

	logic [rpm_pkg::COUNT_BITS-1:0] window_q;
	rpm_pkg::cmd_t                  cmd;
	rpm_pkg::stat_t                 stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= rpm_pkg::WINDOW_RESET;
		else if (psel && penable && pwrite && (paddr == rpm_pkg::ADDR_WINDOW))
			window_q <= pwdata[rpm_pkg::COUNT_BITS-1:0];
	end

	always_comb begin
		prdata = '0;
		if (paddr == rpm_pkg::ADDR_WINDOW)
			prdata = rpm_pkg::DATA_BITS'(window_q);
	end

	rpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rpm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.window       (window_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rms_level    (rms_level),
		.peak_level   (peak_level),
		.sample_count (sample_count)
	);

endmodule

`default_nettype wire
